// ===== rtl/bitmap_first_fit_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator: assertion macros
// Shared concurrent assertion forms. They sample on i_clk and are disabled
// while i_rst_n is low, so the module that uses them must have both ports.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bffa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bffa assertion failed");

`else

`define BFFA_ASSERT_NOW(lbl, ante, cons)
`define BFFA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Field widths, operation codes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int SIZE_W  = 7;
    localparam int START_W = 6;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Control word for one map cell. When shift is high the cell takes its
    // neighbor's bit, forced to one by set or to zero by clr.
    typedef struct packed {
        logic shift;
        logic set;
        logic clr;
    } t_cell_ctl;

endpackage

// ===== rtl/bffa_cell.sv =====
// ----------------------------------------------------------------------------
// Occupancy map cell
// Holds one occupancy bit and loads the bit of its neighbor on every shift.
// ----------------------------------------------------------------------------
module bffa_cell
    import bffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_din,
    output logic      o_q
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.shift) begin
            n_bit = (i_din | i_ctl.set) & ~i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_q = r_bit;

endmodule

// ===== rtl/bffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Rotates the map once past the head cell per pass, counts free runs during
// a search, and drives the set or clear window onto the bit that re-enters
// at the tail. Holds the result register of the output channel.
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_allocator_defines.svh"

module bffa_ctrl
    import bffa_pkg::*;
#(
    parameter int UNITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [SIZE_W-1:0]  i_size_units,
    input  logic [START_W-1:0] i_free_start,
    input  logic               i_head,
    output t_cell_ctl          o_tail_ctl,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted,
    output logic [START_W-1:0] o_start_unit
);

    localparam int IW = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CW = $clog2(UNITS + 1);
    localparam int WW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int XW = WW + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_MARK   = 5'b00100,
        ST_FREE   = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size, n_size;
    logic [START_W-1:0] r_start, n_start;
    logic [CW-1:0]      r_pos, n_pos;
    logic [WW-1:0]      r_run, n_run;
    logic               r_found, n_found;
    logic [IW-1:0]      r_loc, n_loc;
    logic               r_out_valid, n_out_valid;
    logic               r_granted, n_granted;
    logic [START_W-1:0] r_start_unit, n_start_unit;

    logic [XW-1:0] pos_x, size_x, start_x, loc_x, run_x, in_size_x, loc_calc;
    logic [WW-1:0] run_step;
    logic          last, hit, in_acc, out_free, shift;

    always_comb begin
        pos_x     = XW'(r_pos);
        size_x    = XW'(r_size);
        start_x   = XW'(r_start);
        loc_x     = XW'(r_loc);
        in_size_x = XW'(i_size_units);
        run_step  = i_head ? '0 : r_run + WW'(1);
        run_x     = XW'(run_step);
        loc_calc  = pos_x + XW'(1) - size_x;
        last      = (r_pos == CW'(UNITS - 1));
        hit       = !r_found && (run_x == size_x);
        in_acc    = i_in_valid && (r_state == ST_IDLE);
        out_free  = !r_out_valid || !i_out_stall;
        shift     = r_state inside {ST_SEARCH, ST_MARK, ST_FREE};
    end

    always_comb begin
        o_tail_ctl.shift = shift;
        o_tail_ctl.set   = (r_state == ST_MARK)
                           && (pos_x >= loc_x) && (pos_x < loc_x + size_x);
        o_tail_ctl.clr   = (r_state == ST_FREE)
                           && (pos_x >= start_x) && (pos_x < start_x + size_x);
    end

    always_comb begin
        n_state      = r_state;
        n_size       = r_size;
        n_start      = r_start;
        n_pos        = r_pos;
        n_run        = r_run;
        n_found      = r_found;
        n_loc        = r_loc;
        n_out_valid  = r_out_valid && i_out_stall;
        n_granted    = r_granted;
        n_start_unit = r_start_unit;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_size  = i_size_units;
                    n_start = i_free_start;
                    n_pos   = '0;
                    n_run   = '0;
                    n_loc   = '0;
                    if (i_kind == KIND_FREE) begin
                        n_found = 1'b1;
                        n_state = ST_FREE;
                    end else if ((i_size_units != '0) && (in_size_x <= XW'(UNITS))) begin
                        n_found = 1'b0;
                        n_state = ST_SEARCH;
                    end else begin
                        n_found = 1'b0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                n_run = run_step;
                n_pos = r_pos + CW'(1);
                if (hit) begin
                    n_found = 1'b1;
                    n_loc   = loc_calc[IW-1:0];
                end
                if (last) begin
                    n_pos   = '0;
                    n_state = (r_found || hit) ? ST_MARK : ST_DONE;
                end
            end
            ST_MARK, ST_FREE: begin
                n_pos = r_pos + CW'(1);
                if (last) begin
                    n_pos   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait here if the previous result has not been taken yet.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_granted    = r_found;
                    n_start_unit = loc_x[START_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_start      <= n_start;
        r_pos        <= n_pos;
        r_run        <= n_run;
        r_found      <= n_found;
        r_loc        <= n_loc;
        r_granted    <= n_granted;
        r_start_unit <= n_start_unit;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_granted;
    assign o_start_unit = r_start_unit;

    `BFFA_ASSERT_NEXT(a_acc_busy, in_acc, r_state != ST_IDLE)
    `BFFA_ASSERT_NEXT(a_search_one_pass, (r_state == ST_SEARCH) && last, r_state != ST_SEARCH)
    `BFFA_ASSERT_NOW(a_run_fits, r_state == ST_MARK, r_found && (loc_x + size_x <= XW'(UNITS)))
    `BFFA_ASSERT_NOW(a_deny_zero, r_out_valid && !r_granted, r_start_unit == '0)
    `BFFA_ASSERT_NEXT(a_result_held, r_out_valid && i_out_stall,
                      r_out_valid && $stable(r_granted) && $stable(r_start_unit))

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Allocate: when granted, the result is registered after a search pass and then a mark pass,
// after the search pass alone when no run fits, and with no pass when size is zero or exceeds UNITS.
// Free: result registered after one clearing pass.
// Each pass rotates the cell chain once past the head; one item is in work at a time.
// Synchronous reset clears the whole map (all units free) and empties the result register.
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// Occupancy map held in a ring of one-bit cells that rotates past a sequencer.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator
    import bffa_pkg::*;
#(
    parameter int UNITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [SIZE_W-1:0]  i_size_units,
    input  logic [START_W-1:0] i_free_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted,
    output logic [START_W-1:0] o_start_unit
);

    logic      cell_q [UNITS];
    t_cell_ctl tail_ctl;
    t_cell_ctl body_ctl;

    // Only the tail cell sees the set or clear window; the rest just shift.
    always_comb begin
        body_ctl.shift = tail_ctl.shift;
        body_ctl.set   = 1'b0;
        body_ctl.clr   = 1'b0;
    end

    bffa_ctrl #(
        .UNITS (UNITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_size_units (i_size_units),
        .i_free_start (i_free_start),
        .i_head       (cell_q[0]),
        .o_tail_ctl   (tail_ctl),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_granted    (o_granted),
        .o_start_unit (o_start_unit)
    );

    for (genvar k = 0; k < UNITS; k++) begin : g_cell
        if (k == UNITS - 1) begin : g_tail
            bffa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (tail_ctl),
                .i_din   (cell_q[0]),
                .o_q     (cell_q[k])
            );
        end else begin : g_body
            bffa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (body_ctl),
                .i_din   (cell_q[k+1]),
                .o_q     (cell_q[k])
            );
        end
    end

endmodule
